// ===== hdl/fixed_point_line_into_tiled_bitmap_unit_defines.svh =====
// Assertion macros for the tiled bitmap line unit.
`ifndef FIXED_POINT_LINE_INTO_TILED_BITMAP_UNIT_DEFINES_SVH
`define FIXED_POINT_LINE_INTO_TILED_BITMAP_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FLTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define FLTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/fltb_pkg.sv =====
// Package with types and constants for the tiled bitmap line unit.
`timescale 1ns / 1ps
package fltb_pkg;
  localparam int unsigned SCREEN_WIDTH_DEF  = 320;
  localparam int unsigned SCREEN_HEIGHT_DEF = 200;
  localparam int unsigned FRAME_BYTES_DEF   = 8192;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ADDR_IN_W = 13;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_LINE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DIV   = 10'b0000000010,
    ST_PT    = 10'b0000000100,
    ST_ADDR  = 10'b0000001000,
    ST_RD    = 10'b0000010000,
    ST_WR    = 10'b0000100000,
    ST_CLR   = 10'b0001000000,
    ST_RDREQ = 10'b0010000000,
    ST_RDDAT = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;
endpackage

// ===== hdl/fixed_point_line_into_tiled_bitmap_unit.sv =====
// Top level of the tiled bitmap unit: command sequencer, line stepper and frame store.
// A line command first runs the restoring divider (22 steps); every pixel then
// costs a read, then a write of the single-port frame store. A clear writes
// every byte of the store; a read fetches one byte.
// Throughput: one command at a time; in_ready is low until its result transfer.
// Reset (rst_n synchronous, active low) starts a clearing pass over the whole
// store, during which no command is accepted.
`timescale 1ns / 1ps
`include "fixed_point_line_into_tiled_bitmap_unit_defines.svh"
module fixed_point_line_into_tiled_bitmap_unit #(
  parameter int unsigned SCREEN_WIDTH  = fltb_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = fltb_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned FRAME_BYTES   = fltb_pkg::FRAME_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_opcode,
  input  logic signed [fltb_pkg::COORD_W-1:0]    in_x_start,
  input  logic signed [fltb_pkg::COORD_W-1:0]    in_y_start,
  input  logic signed [fltb_pkg::COORD_W-1:0]    in_x_end,
  input  logic signed [fltb_pkg::COORD_W-1:0]    in_y_end,
  input  logic                                   in_ink,
  input  logic [fltb_pkg::ADDR_IN_W-1:0]         in_byte_address,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [7:0]                             out_read_data,
  output logic [1:0]                             out_command_echo
);
  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CELLS_PER_ROW = (SCREEN_WIDTH + 7) / 8;
  // Byte address arithmetic runs wide enough to compare against FRAME_BYTES.
  localparam int unsigned PW = 24;
  localparam int unsigned DW = 24;  // divider width: |short|<<8 fits in 21 bits
  localparam int unsigned CW = 14;  // coordinate width of a stepped point

  // The frame store: one port, registered read data.
  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] mem_q_r;
  logic       mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem[mem_addr];
  end

  fltb_pkg::state_t state_r, state_nxt;
  logic [1:0] op_r;
  logic       ink_r;
  logic       ymaj_r, neg_step_r, neg_short_r;
  logic signed [CW-1:0] x0_r, y0_r;
  logic [12:0] len_r;      // |long| and step count
  logic [12:0] i_r;
  logic [DW-1:0] rem_r, quo_r, dvd_r;
  logic [4:0] dcnt_r;
  logic signed [DW+1:0] slope_r, acc_r;
  logic signed [CW-1:0] px_r, py_r;
  logic [PW-1:0] paddr_r;
  logic       pok_r;
  logic [2:0] pbit_r;
  logic [AW:0] clr_r;
  logic [7:0] rdata_r;
  logic       out_valid_r;
  // Set by reset so that the power-up clearing pass ends without a result.
  logic       boot_r;

  // Command field differences and lengths.
  logic signed [CW-1:0] dx, dy, adx, ady;
  always_comb begin
    dx  = CW'(in_x_end) - CW'(in_x_start);
    dy  = CW'(in_y_end) - CW'(in_y_start);
    adx = dx[CW-1] ? -dx : dx;
    ady = dy[CW-1] ? -dy : dy;
  end

  // One restoring-division step per cycle: slope magnitude = (|short|<<8)/|long|.
  logic [DW:0] trial;
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]} - {{(DW-12){1'b0}}, len_r};
  end

  // Minor-axis offset: floor of the signed 18.8 accumulator.
  logic signed [DW+1:0] minor;
  logic signed [CW-1:0] cx, cy;
  always_comb begin
    minor = acc_r >>> 8;
    if (ymaj_r) begin
      cx = x0_r + CW'(minor);
      cy = neg_step_r ? y0_r - CW'(i_r) : y0_r + CW'(i_r);
    end else begin
      cx = neg_step_r ? x0_r - CW'(i_r) : x0_r + CW'(i_r);
      cy = y0_r + CW'(minor);
    end
  end

  logic [7:0] mask;
  always_comb begin
    mask = 8'h80 >> pbit_r;
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_addr  = paddr_r[AW-1:0];
    mem_wd    = ink_r ? (mem_q_r | mask) : (mem_q_r & ~mask);
    unique case (state_r)
      fltb_pkg::ST_IDLE: begin
        if (in_valid && !out_valid_r) begin
          unique case (fltb_pkg::opcode_t'(in_opcode))
            fltb_pkg::OP_PIXEL: state_nxt = fltb_pkg::ST_PT;
            fltb_pkg::OP_LINE:  state_nxt = fltb_pkg::ST_DIV;
            fltb_pkg::OP_CLEAR: state_nxt = fltb_pkg::ST_CLR;
            fltb_pkg::OP_READ:  state_nxt = fltb_pkg::ST_RDREQ;
            default:            state_nxt = fltb_pkg::ST_OUT;
          endcase
        end
      end
      fltb_pkg::ST_DIV: if (dcnt_r == 5'd0) state_nxt = fltb_pkg::ST_PT;
      fltb_pkg::ST_PT: begin
        if (op_r == fltb_pkg::OP_LINE && i_r == len_r) state_nxt = fltb_pkg::ST_OUT;
        else state_nxt = fltb_pkg::ST_ADDR;
      end
      // The on-screen flag settles here; the write cycle uses it.
      fltb_pkg::ST_ADDR: state_nxt = fltb_pkg::ST_RD;
      fltb_pkg::ST_RD: state_nxt = fltb_pkg::ST_WR;
      fltb_pkg::ST_WR: begin
        mem_we = pok_r;
        state_nxt = (op_r == fltb_pkg::OP_LINE) ? fltb_pkg::ST_PT : fltb_pkg::ST_OUT;
      end
      fltb_pkg::ST_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r[AW-1:0];
        mem_wd   = 8'h00;
        if (clr_r == (AW+1)'(FRAME_BYTES - 1)) begin
          state_nxt = boot_r ? fltb_pkg::ST_IDLE : fltb_pkg::ST_OUT;
        end
      end
      fltb_pkg::ST_RDREQ: state_nxt = fltb_pkg::ST_RDDAT;
      fltb_pkg::ST_RDDAT: state_nxt = fltb_pkg::ST_OUT;
      fltb_pkg::ST_OUT: state_nxt = fltb_pkg::ST_IDLE;
      default: state_nxt = fltb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fltb_pkg::ST_CLR;
      op_r        <= fltb_pkg::OP_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      boot_r      <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        fltb_pkg::ST_IDLE: begin
          boot_r <= 1'b0;
          if (in_valid && !out_valid_r) begin
            op_r    <= in_opcode;
            ink_r   <= in_ink;
            x0_r    <= CW'(in_x_start);
            y0_r    <= CW'(in_y_start);
            clr_r   <= '0;
            rdata_r <= 8'h00;
            i_r     <= '0;
            acc_r   <= '0;
            dcnt_r  <= 5'd21;
            rem_r   <= '0;
            quo_r   <= '0;
            // A read keeps its byte address here for the store access.
            paddr_r <= PW'(in_byte_address);
            ymaj_r  <= ady > adx;
            // Short axis magnitude shifted into the dividend's top bits.
            if (ady > adx) begin
              len_r       <= 13'(ady);
              neg_step_r  <= dy[CW-1];
              neg_short_r <= dx[CW-1];
              dvd_r       <= DW'({adx, 8'h00}) << 2;
            end else begin
              len_r       <= 13'(adx);
              neg_step_r  <= dx[CW-1];
              neg_short_r <= dy[CW-1];
              dvd_r       <= DW'({ady, 8'h00}) << 2;
            end
          end
        end
        fltb_pkg::ST_DIV: begin
          // 22 dividend bits, one quotient bit per cycle.
          dcnt_r <= dcnt_r - 5'd1;
          dvd_r  <= dvd_r << 1;
          if (!trial[DW]) begin
            rem_r <= trial[DW-1:0];
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DW-2:0], dvd_r[DW-1]};
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
          if (dcnt_r == 5'd0) begin
            slope_r <= neg_short_r ? -(DW+2)'({1'b0, quo_r[DW-2:0], !trial[DW]})
                                   : (DW+2)'({1'b0, quo_r[DW-2:0], !trial[DW]});
          end
        end
        fltb_pkg::ST_PT: begin
          if (op_r == fltb_pkg::OP_LINE) begin
            px_r <= cx;
            py_r <= cy;
          end else begin
            px_r <= x0_r;
            py_r <= y0_r;
          end
        end
        fltb_pkg::ST_ADDR: begin
          // One multiply-add per point for the tiled byte address.
          pok_r <= !px_r[CW-1] && !py_r[CW-1] && px_r < CW'(SCREEN_WIDTH)
                   && py_r < CW'(SCREEN_HEIGHT)
                   && ((PW'(PW'(py_r >>> 3) * PW'(CELLS_PER_ROW) + PW'(px_r >>> 3)) << 3)
                       + PW'(py_r[2:0])) < PW'(FRAME_BYTES);
          paddr_r <= (PW'(PW'(py_r >>> 3) * PW'(CELLS_PER_ROW) + PW'(px_r >>> 3)) << 3)
                     + PW'(py_r[2:0]);
          pbit_r <= px_r[2:0];
        end
        fltb_pkg::ST_WR: begin
          i_r   <= i_r + 13'd1;
          acc_r <= acc_r + slope_r;
        end
        fltb_pkg::ST_CLR: clr_r <= clr_r + 1'b1;
        fltb_pkg::ST_RDREQ: ;
        fltb_pkg::ST_RDDAT: begin
          rdata_r <= (paddr_r < PW'(FRAME_BYTES)) ? mem_q_r : 8'h00;
        end
        fltb_pkg::ST_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign in_ready         = (state_r == fltb_pkg::ST_IDLE) && !out_valid_r;
  assign out_valid        = out_valid_r;
  assign out_read_data    = rdata_r;
  assign out_command_echo = op_r;

  `FLTB_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == fltb_pkg::ST_IDLE)
  `FLTB_ASSERT_IMP(a_no_both, clk, rst_n, out_valid_r, !in_ready)
  `FLTB_ASSERT_NEXT(a_out_after, clk, rst_n, state_r == fltb_pkg::ST_OUT, out_valid_r)
endmodule
